// ----- src/gpio_irq_pkg.sv -----
// Package for the GPIO pin controller with edge interrupts.
// Holds payload structs, register map offsets, codes and the address decoder.
// No dependencies.
`default_nettype none

package gpio_irq_pkg;

  localparam int PIN_COUNT = 128;
  localparam int PIN_W     = 7;   // width of the pin fields
  localparam int ADDR_W    = 14;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;

  // item kinds
  localparam logic [1:0] F_READ  = 2'd0;
  localparam logic [1:0] F_WRITE = 2'd1;
  localparam logic [1:0] F_PIN   = 2'd2;

  // access status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [1:0] ST_READ_ONLY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ID1 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID2 = 1'd1;

  localparam logic [DATA_W-1:0] ID1_RESET = 32'h5737_3001;
  localparam logic [DATA_W-1:0] ID2_RESET = 32'h0;

  // register map
  localparam logic [ADDR_W-1:0] A_ID1    = 14'h0004;
  localparam logic [ADDR_W-1:0] A_ID2    = 14'h0008;
  localparam logic [ADDR_W-1:0] A_STATUS = 14'h0010;
  localparam logic [ADDR_W-1:0] A_ENABLE = 14'h0018;
  localparam logic [ADDR_W-1:0] A_SELECT = 14'h001C;
  localparam logic [ADDR_W-1:0] A_RISE   = 14'h0020;
  localparam logic [ADDR_W-1:0] A_FALL   = 14'h0024;
  localparam logic [ADDR_W-1:0] A_FILTER = 14'h0028;
  localparam logic [ADDR_W-1:0] A_CTRL   = 14'h0240;
  localparam logic [ADDR_W-1:0] A_DOUT   = 14'h1300;
  localparam logic [ADDR_W-1:0] A_DIN    = 14'h1500;
  localparam logic [ADDR_W-1:0] A_CTRL_END = ADDR_W'(14'h0240 + 4 * PIN_COUNT);
  localparam logic [ADDR_W-1:0] A_DOUT_END = ADDR_W'(14'h1300 + PIN_COUNT);
  localparam logic [ADDR_W-1:0] A_DIN_END  = ADDR_W'(14'h1500 + PIN_COUNT);

  localparam int BIT_OUT_BUF = 21;
  localparam int BIT_IN_BUF  = 19;

  // decoded pin window
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_CTRL = 2'd1;
  localparam logic [1:0] K_DOUT = 2'd2;
  localparam logic [1:0] K_DIN  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] bus_addr;
    logic [DATA_W-1:0] write_data;
    logic [PIN_W-1:0]  pin_index;
    logic              pin_level;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [1:0]        access_status;
    logic              irq_pulse;
    logic              drive_valid;
    logic [PIN_W-1:0]  drive_pin;
    logic              drive_level;
  } out_item_t;

  // one per-pin entry: control word plus data bits
  typedef struct packed {
    logic              last_level;
    logic              in_data;
    logic              out_data;
    logic [DATA_W-1:0] ctrl;
  } pin_entry_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PIN_W-1:0] pin;
  } pin_decode_t;

  function automatic pin_decode_t decode_pin(input logic [ADDR_W-1:0] a);
    pin_decode_t d;
    logic [ADDR_W-1:0] off;
    d.kind = K_NONE;
    d.pin  = '0;
    off    = '0;
    if (a >= A_CTRL && a < A_CTRL_END) begin
      off    = a - A_CTRL;
      d.kind = K_CTRL;
      d.pin  = off[PIN_W+1:2];
    end else if (a >= A_DOUT && a < A_DOUT_END) begin
      off    = a - A_DOUT;
      d.kind = K_DOUT;
      d.pin  = off[PIN_W-1:0];
    end else if (a >= A_DIN && a < A_DIN_END) begin
      off    = a - A_DIN;
      d.kind = K_DIN;
      d.pin  = off[PIN_W-1:0];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/gpio_pin_controller_edge_irq_top.sv -----
// GPIO pin controller with edge interrupts: register window, per-pin store,
// edge detection. Depends on gpio_irq_pkg.
// Flow: an accepted item waits in the work register (stage 1), then loads the
//   result register once that register is empty or being drained by out_ready.
// Throughput: one item per cycle unless the result side stalls; the per-pin store
//   is read at accept, written as the item leaves stage 1, with a bypass between them.
// Reset (synchronous, rst high): pipeline empties, word registers clear, ID
//   words take their reset values, all per-pin valid bits clear so every pin
//   entry reads as zero until written. No clearing pass is needed.
`default_nettype none

module gpio_pin_controller_edge_irq_top import gpio_irq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  // ID words, written only through the config port
  logic [DATA_W-1:0] mcu_id_word1;
  logic [DATA_W-1:0] mcu_id_word2;

  // word-wide registers
  logic [DATA_W-1:0] irq_status, irq_status_next;
  logic [DATA_W-1:0] irq_enable, irq_enable_next;
  logic [DATA_W-1:0] request_select, request_select_next;
  logic [DATA_W-1:0] rise_enable, rise_enable_next;
  logic [DATA_W-1:0] fall_enable, fall_enable_next;
  logic [DATA_W-1:0] filter_enable, filter_enable_next;

  // per-pin store: memory plus one valid bit per pin (invalid reads as zero)
  pin_entry_t           pin_mem [PIN_COUNT];
  logic [PIN_COUNT-1:0] ent_valid;

  // work register (stage 1)
  logic        s1_valid;
  in_item_t    s1_item;
  pin_decode_t s1_dec;
  pin_entry_t  rd_raw;
  logic        rd_vld;

  // store write port, driven from stage 1
  logic             wr_en;
  logic [PIN_W-1:0] wr_addr;
  pin_entry_t       wr_data;

  logic        in_fire, s1_fire;
  pin_decode_t in_dec;
  logic [PIN_W-1:0] rd_addr;
  out_item_t   res;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // pin index for the store read: event pin or decoded bus pin
  always_comb begin
    in_dec  = decode_pin(in_item.bus_addr);
    rd_addr = (in_item.func == F_PIN) ? in_item.pin_index : in_dec.pin;
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      mcu_id_word1 <= ID1_RESET;
      mcu_id_word2 <= ID2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID1: mcu_id_word1 <= cfg_data;
        CFG_ID2: mcu_id_word2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // store: registered read at accept, bypass from the write of the item ahead
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pin_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_raw <= wr_data;
      end else begin
        rd_raw <= pin_mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld <= ent_valid[rd_addr] || (wr_en && wr_addr == rd_addr);
      end
    end
  end

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
      s1_dec  <= in_dec;
    end
  end

  // single-pass work on the item in stage 1
  always_comb begin
    pin_entry_t       ent;
    logic [DATA_W-1:0] m;
    logic              hit;
    ent = rd_vld ? rd_raw : '0;
    m   = DATA_W'(1) << s1_item.pin_index[4:0];
    hit = 1'b0;

    irq_status_next     = irq_status;
    irq_enable_next     = irq_enable;
    request_select_next = request_select;
    rise_enable_next    = rise_enable;
    fall_enable_next    = fall_enable;
    filter_enable_next  = filter_enable;

    wr_en   = 1'b0;
    wr_addr = (s1_item.func == F_PIN) ? s1_item.pin_index : s1_dec.pin;
    wr_data = ent;
    res     = '0;

    case (s1_item.func)
      F_READ: begin
        case (s1_item.bus_addr)
          A_ID1:    res.read_data = mcu_id_word1;
          A_ID2:    res.read_data = mcu_id_word2;
          A_STATUS: res.read_data = irq_status;
          A_ENABLE: res.read_data = irq_enable;
          A_SELECT: res.read_data = request_select;
          A_RISE:   res.read_data = rise_enable;
          A_FALL:   res.read_data = fall_enable;
          A_FILTER: res.read_data = filter_enable;
          default: begin
            case (s1_dec.kind)
              K_CTRL:  res.read_data = ent.ctrl;
              K_DOUT:  res.read_data = DATA_W'(ent.out_data);
              K_DIN:   res.read_data = DATA_W'(ent.in_data);
              default: res.access_status = ST_UNMAPPED;
            endcase
          end
        endcase
      end
      F_WRITE: begin
        case (s1_item.bus_addr)
          A_STATUS: irq_status_next     = irq_status & ~s1_item.write_data;
          A_ENABLE: irq_enable_next     = s1_item.write_data;
          A_SELECT: request_select_next = s1_item.write_data;
          A_RISE:   rise_enable_next    = s1_item.write_data;
          A_FALL:   fall_enable_next    = s1_item.write_data;
          A_FILTER: filter_enable_next  = s1_item.write_data;
          default: begin
            case (s1_dec.kind)
              K_CTRL: begin
                wr_en        = 1'b1;
                wr_data.ctrl = s1_item.write_data;
              end
              K_DOUT: begin
                wr_en            = 1'b1;
                wr_data.out_data = s1_item.write_data[0];
                if (ent.ctrl[BIT_OUT_BUF]) begin
                  res.drive_valid = 1'b1;
                  res.drive_pin   = s1_dec.pin;
                  res.drive_level = s1_item.write_data[0];
                end
              end
              K_DIN:   res.access_status = ST_READ_ONLY;
              default: res.access_status = ST_UNMAPPED;
            endcase
          end
        endcase
      end
      F_PIN: begin
        // level change taken only with the input buffer on
        if (int'(s1_item.pin_index) < PIN_COUNT && ent.ctrl[BIT_IN_BUF]) begin
          wr_en              = 1'b1;
          wr_data.in_data    = s1_item.pin_level;
          wr_data.last_level = s1_item.pin_level;
          // edge interrupts exist for the low 32 pins only
          if (s1_item.pin_index[PIN_W-1:5] == '0 && (irq_enable & m) != '0) begin
            if ((rise_enable & m) != '0 && !ent.last_level && s1_item.pin_level) begin
              hit = 1'b1;
            end
            if ((fall_enable & m) != '0 && ent.last_level && !s1_item.pin_level) begin
              hit = 1'b1;
            end
          end
          if (hit) begin
            irq_status_next = irq_status | m;
            res.irq_pulse   = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (!s1_fire) begin
      wr_en = 1'b0;
    end
  end

  // word registers advance with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_status     <= '0;
      irq_enable     <= '0;
      request_select <= '0;
      rise_enable    <= '0;
      fall_enable    <= '0;
      filter_enable  <= '0;
    end else if (s1_fire) begin
      irq_status     <= irq_status_next;
      irq_enable     <= irq_enable_next;
      request_select <= request_select_next;
      rise_enable    <= rise_enable_next;
      fall_enable    <= fall_enable_next;
      filter_enable  <= filter_enable_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= res;
    end
  end

  // a level change and a pin drive never come from the same item
  a_irq_drive_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.irq_pulse && out_item.drive_valid))
    else $error("irq pulse and pin drive in one item");

  // a pin drive only comes from a successful write
  a_drive_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.drive_valid) |-> (out_item.access_status == ST_OK))
    else $error("pin drive with bad access status");

  // an empty result register never blocks intake
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("intake stalled with empty result register");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- verif/gpio_pin_controller_edge_irq_top_tb.sv -----
// Self-checking testbench for gpio_pin_controller_edge_irq_top.
// Drives bus reads, bus writes and pin level changes, predicts every result in a
// scoreboard class and compares field by field. Depends on gpio_irq_pkg and the top.
`default_nettype none

module gpio_pin_controller_edge_irq_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpio_irq_pkg::*;

  localparam logic [1:0] F_UNUSED = 2'd3;   // item kind the block ignores
  localparam int ITEMS_PER_PHASE = 500;
  localparam int SETTLE = 6;                // settling wait after a drain
  localparam int IRQ_PINS = 32;             // only pins below this raise interrupts

  // Mirror of the block's state; one expected result per accepted item.
  class gpio_scoreboard;
    logic [DATA_W-1:0] ctrl_word  [PIN_COUNT];
    logic              dout_bit   [PIN_COUNT];
    logic              din_bit    [PIN_COUNT];
    logic              drives_out [PIN_COUNT];
    logic              listens    [PIN_COUNT];
    logic              prev_level [PIN_COUNT];
    logic [DATA_W-1:0] irq_status, irq_enable, req_select;
    logic [DATA_W-1:0] rise_en, fall_en, filter_en;
    logic [DATA_W-1:0] id_word1, id_word2;
    out_item_t         expected_q[$];
    int                errors;
    int                results_seen;

    function new();
      foreach (ctrl_word[i]) begin
        ctrl_word[i]  = '0;
        dout_bit[i]   = 1'b0;
        din_bit[i]    = 1'b0;
        drives_out[i] = 1'b0;
        listens[i]    = 1'b0;
        prev_level[i] = 1'b0;
      end
      irq_status   = '0;
      irq_enable   = '0;
      req_select   = '0;
      rise_en      = '0;
      fall_en      = '0;
      filter_en    = '0;
      id_word1     = ID1_RESET;
      id_word2     = ID2_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_id(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      if (idx == CFG_ID1) id_word1 = v;
      else id_word2 = v;
    endfunction

    // per-pin windows: control words are 4 bytes apart, data bits 1 byte apart
    function pin_decode_t locate(logic [ADDR_W-1:0] a);
      pin_decode_t d;
      int          ia;
      ia     = int'(a);
      d.kind = K_NONE;
      d.pin  = '0;
      if (ia >= int'(A_CTRL) && ia < int'(A_CTRL) + 4 * PIN_COUNT) begin
        d.kind = K_CTRL;
        d.pin  = PIN_W'((ia - int'(A_CTRL)) / 4);
      end else if (ia >= int'(A_DOUT) && ia < int'(A_DOUT) + PIN_COUNT) begin
        d.kind = K_DOUT;
        d.pin  = PIN_W'(ia - int'(A_DOUT));
      end else if (ia >= int'(A_DIN) && ia < int'(A_DIN) + PIN_COUNT) begin
        d.kind = K_DIN;
        d.pin  = PIN_W'(ia - int'(A_DIN));
      end
      return d;
    endfunction

    function out_item_t predict(in_item_t it);
      out_item_t         r;
      pin_decode_t       d;
      logic [DATA_W-1:0] m;
      logic              old;
      r = '0;
      d = locate(it.bus_addr);
      case (it.func)
        F_READ: begin
          case (it.bus_addr)
            A_ID1:    r.read_data = id_word1;
            A_ID2:    r.read_data = id_word2;
            A_STATUS: r.read_data = irq_status;
            A_ENABLE: r.read_data = irq_enable;
            A_SELECT: r.read_data = req_select;
            A_RISE:   r.read_data = rise_en;
            A_FALL:   r.read_data = fall_en;
            A_FILTER: r.read_data = filter_en;
            default: begin
              case (d.kind)
                K_CTRL:  r.read_data = ctrl_word[d.pin];
                K_DOUT:  r.read_data = DATA_W'(dout_bit[d.pin]);
                K_DIN:   r.read_data = DATA_W'(din_bit[d.pin]);
                default: r.access_status = ST_UNMAPPED;
              endcase
            end
          endcase
        end
        F_WRITE: begin
          case (it.bus_addr)
            A_STATUS: irq_status = irq_status & ~it.write_data;
            A_ENABLE: irq_enable = it.write_data;
            A_SELECT: req_select = it.write_data;
            A_RISE:   rise_en    = it.write_data;
            A_FALL:   fall_en    = it.write_data;
            A_FILTER: filter_en  = it.write_data;
            default: begin
              case (d.kind)
                K_CTRL: begin
                  ctrl_word[d.pin]  = it.write_data;
                  drives_out[d.pin] = it.write_data[BIT_OUT_BUF];
                  listens[d.pin]    = it.write_data[BIT_IN_BUF];
                end
                K_DOUT: begin
                  dout_bit[d.pin] = it.write_data[0];
                  if (drives_out[d.pin]) begin
                    r.drive_valid = 1'b1;
                    r.drive_pin   = d.pin;
                    r.drive_level = it.write_data[0];
                  end
                end
                K_DIN:   r.access_status = ST_READ_ONLY;
                default: r.access_status = ST_UNMAPPED;  // ID words land here too
              endcase
            end
          endcase
        end
        F_PIN: begin
          if (listens[it.pin_index]) begin
            din_bit[it.pin_index] = it.pin_level;
            old = prev_level[it.pin_index];
            if (it.pin_index < IRQ_PINS) begin
              m = DATA_W'(1) << it.pin_index;
              if ((irq_enable & m) != 0) begin
                if (((rise_en & m) != 0 && !old && it.pin_level) ||
                    ((fall_en & m) != 0 && old && !it.pin_level)) begin
                  irq_status  = irq_status | m;
                  r.irq_pulse = 1'b1;
                end
              end
            end
            prev_level[it.pin_index] = it.pin_level;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(predict(it));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
      errors++;
    endtask

    task cmp(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      cmp("read_data", got.read_data, want.read_data);
      cmp("access_status", DATA_W'(got.access_status), DATA_W'(want.access_status));
      cmp("irq_pulse", DATA_W'(got.irq_pulse), DATA_W'(want.irq_pulse));
      cmp("drive_valid", DATA_W'(got.drive_valid), DATA_W'(want.drive_valid));
      cmp("drive_pin", DATA_W'(got.drive_pin), DATA_W'(want.drive_pin));
      cmp("drive_level", DATA_W'(got.drive_level), DATA_W'(want.drive_level));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  gpio_scoreboard sb;
  int             burst_left = 0;

  gpio_pin_controller_edge_irq_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop in case a handshake hangs; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. The receiver switches at random between styles of back-pressure:
  // wide open, coin flip, mostly stalled and a fixed three-of-four beat. Ready
  // changes on the falling edge only.
  // ---------------------------------------------------------------------------
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} rx_style_e;
  rx_style_e rx_style = RX_OPEN;
  int        rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_left  = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_style)
      RX_OPEN: out_ready = 1'b1;
      RX_COIN: out_ready = 1'($urandom_range(0, 1));
      RX_SLOW: out_ready = ($urandom_range(0, 3) == 0);
      default: out_ready = (rx_left % 4 != 0);
    endcase
  end

  // Results are taken at the rising edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // ---------------------------------------------------------------------------
  // Item side helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                  logic [DATA_W-1:0] data, logic [PIN_W-1:0] pin,
                                  logic lvl);
    in_item_t it;
    it.func       = func;
    it.bus_addr   = addr;
    it.write_data = data;
    it.pin_index  = pin;
    it.pin_level  = lvl;
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] word_reg(int k);
    case (k)
      0:       return A_ID1;
      1:       return A_ID2;
      2:       return A_STATUS;
      3:       return A_ENABLE;
      4:       return A_SELECT;
      5:       return A_RISE;
      6:       return A_FALL;
      default: return A_FILTER;
    endcase
  endfunction

  // Mostly the interrupt-capable pins, so edges and status bits get exercised.
  function automatic logic [PIN_W-1:0] pick_pin();
    if ($urandom_range(0, 9) < 7) return PIN_W'($urandom_range(0, IRQ_PINS - 1));
    return PIN_W'($urandom_range(0, PIN_COUNT - 1));
  endfunction

  // Mostly mapped accesses and pin events on configured pins; a small share of
  // fully random items keeps every address and kind bit moving.
  function automatic in_item_t random_item();
    in_item_t         it;
    logic [PIN_W-1:0] pin;
    int               roll;
    int               k;
    it.func       = F_READ;
    it.bus_addr   = ADDR_W'($urandom);
    it.write_data = $urandom;
    it.pin_index  = PIN_W'($urandom);
    it.pin_level  = 1'($urandom);
    pin  = pick_pin();
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      it.func      = F_PIN;
      it.pin_index = pin;
    end else if (roll < 45) begin
      // control word: input buffer usually on, any byte of the word
      it.func     = F_WRITE;
      it.bus_addr = ADDR_W'(int'(A_CTRL) + 4 * int'(pin) + $urandom_range(0, 3));
      it.write_data[BIT_IN_BUF]  = ($urandom_range(0, 99) < 85);
      it.write_data[BIT_OUT_BUF] = 1'($urandom_range(0, 1));
    end else if (roll < 55) begin
      it.func     = F_WRITE;
      it.bus_addr = ADDR_W'(int'(A_DOUT) + int'(pin));
    end else if (roll < 63) begin
      // word registers; enables lean toward ones so edges actually fire
      k           = $urandom_range(2, 7);
      it.func     = F_WRITE;
      it.bus_addr = word_reg(k);
      if (k != 2 && $urandom_range(0, 1) == 1) it.write_data = $urandom | $urandom;
    end else if (roll < 88) begin
      it.func = F_READ;
      case ($urandom_range(0, 3))
        0:       it.bus_addr = word_reg($urandom_range(0, 7));
        1:       it.bus_addr = ADDR_W'(int'(A_CTRL) + 4 * int'(pin) + $urandom_range(0, 3));
        2:       it.bus_addr = ADDR_W'(int'(A_DOUT) + int'(pin));
        default: it.bus_addr = ADDR_W'(int'(A_DIN) + int'(pin));
      endcase
    end else if (roll < 93) begin
      // writes the block must refuse
      it.func     = F_WRITE;
      it.bus_addr = ($urandom_range(0, 1) == 1) ? ADDR_W'(int'(A_DIN) + int'(pin))
                                                : word_reg($urandom_range(0, 1));
    end else begin
      it.func = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Holds valid until the item is taken; between bursts the sender goes quiet
  // for a random gap, and about a third of bursts follow on with no gap.
  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_item  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Wait until every outstanding result is back, then let the pipe settle.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ID words may only change while the block is idle; read both back at once.
  task automatic retune_ids(input logic [DATA_W-1:0] w1, input logic [DATA_W-1:0] w2);
    drain();
    cfg_we    = 1'b1;
    cfg_index = CFG_ID1;
    cfg_data  = w1;
    @(negedge clk);
    cfg_index = CFG_ID2;
    cfg_data  = w2;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_id(CFG_ID1, w1);
    sb.set_id(CFG_ID2, w2);
    send_item(mk(F_READ, A_ID1, '0, '0, 1'b0));
    send_item(mk(F_READ, A_ID2, '0, '0, 1'b0));
  endtask

  task automatic run_random(input int count);
    in_item_t it;
    int       done;
    done = 0;
    while (done < count) begin
      it = random_item();
      send_item(it);
      if (it.func != F_UNUSED) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: ID reset values, both edge kinds, the pins above the interrupt
    // range, a pin with its input buffer off, partial status clear, drive and
    // no-drive data writes, refused writes, unmapped offsets, the unused kind.
    send_item(mk(F_READ,  A_ID1, '0, '0, 1'b0));
    send_item(mk(F_READ,  A_ID2, '0, '0, 1'b0));
    send_item(mk(F_WRITE, A_CTRL, 32'h0028_0000, '0, 1'b0));              // pin 0 in+out
    send_item(mk(F_WRITE, A_CTRL + 14'd127, '1, '0, 1'b0));               // pin 31, last byte
    send_item(mk(F_WRITE, A_CTRL + 14'(4 * 127 + 1), 32'h0008_0000, '0, 1'b0));
    send_item(mk(F_WRITE, A_ENABLE, '1, '0, 1'b0));
    send_item(mk(F_WRITE, A_RISE, '1, '0, 1'b0));
    send_item(mk(F_WRITE, A_FALL, 32'h0000_0001, '0, 1'b0));
    send_item(mk(F_PIN, '0, '0, 7'd0, 1'b1));                              // rising, pin 0
    send_item(mk(F_PIN, '0, '0, 7'd0, 1'b0));                              // falling, pin 0
    send_item(mk(F_PIN, '0, '0, 7'd31, 1'b1));                             // rising, pin 31
    send_item(mk(F_PIN, '0, '0, 7'd31, 1'b0));                             // fall not enabled
    send_item(mk(F_PIN, '1, '1, 7'd127, 1'b1));                            // no interrupt
    send_item(mk(F_PIN, '0, '0, 7'd64, 1'b1));                             // buffer off
    send_item(mk(F_READ,  A_STATUS, '0, '0, 1'b0));
    send_item(mk(F_WRITE, A_STATUS, 32'h0000_0001, '0, 1'b0));
    send_item(mk(F_READ,  A_STATUS, '0, '0, 1'b0));
    send_item(mk(F_WRITE, A_DOUT, '1, '0, 1'b0));                          // drives pin 0
    send_item(mk(F_WRITE, A_DOUT + 14'd1, 32'h1, '0, 1'b0));               // pin 1 not driven
    send_item(mk(F_WRITE, A_DOUT + 14'd31, 32'h1, '0, 1'b0));
    send_item(mk(F_WRITE, A_DOUT + 14'd127, '0, '0, 1'b0));
    send_item(mk(F_WRITE, A_DIN, '1, '0, 1'b0));                           // read-only
    send_item(mk(F_WRITE, A_ID1, '1, '0, 1'b0));                           // ID write, unmapped
    send_item(mk(F_READ,  '1, '0, '0, 1'b0));                              // unmapped top
    send_item(mk(F_WRITE, '0, '1, '0, 1'b0));                              // unmapped bottom
    send_item(mk(F_UNUSED, '1, '1, '1, 1'b1));
    send_item(mk(F_READ,  A_DIN + 14'd127, '0, '0, 1'b0));
    send_item(mk(F_READ,  A_CTRL + 14'(4 * 127 + 3), '0, '0, 1'b0));
    send_item(mk(F_READ,  A_DOUT, '0, '0, 1'b0));

    // Random phases, each under a different pair of ID words.
    retune_ids('0, '1);
    run_random(ITEMS_PER_PHASE);
    retune_ids('1, '0);
    run_random(ITEMS_PER_PHASE);
    retune_ids($urandom, $urandom);
    run_random(ITEMS_PER_PHASE);

    drain();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
